// ===== src/u16550_pkg.sv =====
`timescale 1ns / 1ps
// constants, codes and widths of the 16550-style uart register block
// no dependencies; imported by uart_16550_register_model
package u16550_pkg;

  // receive fifo geometry
  localparam int RX_DEPTH = 16;
  localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CNT_W    = $clog2(RX_DEPTH + 1);

  // item commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;

  // register offsets
  localparam logic [2:0] OFF_RBR_THR = 3'd0;
  localparam logic [2:0] OFF_IER     = 3'd1;
  localparam logic [2:0] OFF_IIR_FCR = 3'd2;
  localparam logic [2:0] OFF_LCR     = 3'd3;
  localparam logic [2:0] OFF_MCR     = 3'd4;
  localparam logic [2:0] OFF_LSR     = 3'd5;
  localparam logic [2:0] OFF_MSR     = 3'd6;
  localparam logic [2:0] OFF_SCR     = 3'd7;

  // bit positions and values
  localparam int         LCR_DLAB      = 7;
  localparam int         IER_RDI       = 0;
  localparam int         IER_TX_EMPTY  = 1;
  localparam int         FCR_ENABLE    = 0;
  localparam int         FCR_RX_FLUSH  = 1;
  localparam logic [7:0] LSR_TX_READY  = 8'h60;
  localparam logic [7:0] LSR_DR        = 8'h01;
  localparam logic [7:0] IIR_RDI       = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY  = 8'h02;
  localparam logic [7:0] IIR_NONE      = 8'h01;
  localparam logic [7:0] IIR_FIFO_ON   = 8'hC0;
  localparam logic [7:0] IER_MASK      = 8'h0F;
  localparam logic [7:0] MCR_MASK      = 8'h1F;

  // result fields held in the output register
  typedef struct packed {
    logic [7:0] rdata;
    logic       pop;
    logic       irq_pulse;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       rx_dropped;
  } u16550_res_t;

endpackage

// ===== src/uart_16550_register_model.sv =====
`timescale 1ns / 1ps
// 16550-style uart register block with receive fifo in a synchronous ram
// depends on u16550_pkg
// the result is registered and is valid in the cycle after the input transfer
// throughput: one item per cycle while the output is not stalled; the fifo ram read port and output register set this
// an item is taken whenever the output register is empty or is being drained
// reset (rst_n, synchronous, active low): registers and fifo pointers cleared,
// fifo empty; ram contents are left as they are
module uart_16550_register_model
  import u16550_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [2:0] in_offset,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic       out_irq_pulse,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_data,
  output logic       out_rx_dropped
);

  localparam logic [CNT_W-1:0] RX_FULL  = CNT_W'(RX_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

  // state registers
  logic [PTR_W-1:0] rx_head_r, rx_head_nxt;
  logic [PTR_W-1:0] rx_tail_r, rx_tail_nxt;
  logic [CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       lcr_r, lcr_nxt;
  logic [4:0]       mcr_r, mcr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic [7:0]       fcr_r, fcr_nxt;

  // result register
  logic             out_valid_r;
  u16550_res_t      res_r, res_nxt;

  // fifo ram
  logic [7:0]       rx_mem_r [RX_DEPTH];
  logic [7:0]       rd_data_r;
  logic             mem_we, mem_re;

  logic             in_xfer;
  logic             dlab;
  logic             has_data;
  logic [7:0]       iir_hi;
  logic [3:0]       ier_new;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign dlab     = lcr_r[LCR_DLAB];
  assign has_data = (rx_count_r != '0);
  assign iir_hi   = fcr_r[FCR_ENABLE] ? IIR_FIFO_ON : 8'h00;
  assign ier_new  = 4'(in_wdata & IER_MASK);

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // decode the item, work out register updates and the result
  always_comb begin
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    rx_count_nxt = rx_count_r;
    ier_nxt      = ier_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    scr_nxt      = scr_r;
    fcr_nxt      = fcr_r;
    res_nxt      = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    unique case (in_cmd)
      CMD_READ: begin
        unique case (in_offset)
          OFF_RBR_THR: begin
            if (!dlab && has_data) begin
              mem_re       = 1'b1;
              res_nxt.pop  = 1'b1;
              rx_head_nxt  = next_pos(rx_head_r);
              rx_count_nxt = rx_count_r - CNT_W'(1);
            end
          end
          OFF_IER:     res_nxt.rdata = dlab ? 8'h00 : {4'h0, ier_r};
          OFF_IIR_FCR: begin
            priority if (ier_r[IER_RDI] && has_data) res_nxt.rdata = iir_hi | IIR_RDI;
            else if (ier_r[IER_TX_EMPTY])            res_nxt.rdata = iir_hi | IIR_TX_EMPTY;
            else                                     res_nxt.rdata = iir_hi | IIR_NONE;
          end
          OFF_LCR:     res_nxt.rdata = lcr_r;
          OFF_MCR:     res_nxt.rdata = {3'b000, mcr_r};
          OFF_LSR:     res_nxt.rdata = LSR_TX_READY | (has_data ? LSR_DR : 8'h00);
          OFF_MSR:     res_nxt.rdata = 8'h00;
          OFF_SCR:     res_nxt.rdata = scr_r;
          default:     res_nxt.rdata = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        unique case (in_offset)
          OFF_RBR_THR: begin
            if (!dlab) begin
              res_nxt.tx_valid  = 1'b1;
              res_nxt.tx_data   = in_wdata;
              res_nxt.irq_pulse = ier_r[IER_TX_EMPTY];
            end
          end
          OFF_IER: begin
            if (!dlab) begin
              ier_nxt           = ier_new;
              res_nxt.irq_pulse = (ier_new[IER_RDI] && has_data) || ier_new[IER_TX_EMPTY];
            end
          end
          OFF_IIR_FCR: begin
            fcr_nxt = in_wdata;
            if (in_wdata[FCR_RX_FLUSH]) begin
              rx_head_nxt  = '0;
              rx_tail_nxt  = '0;
              rx_count_nxt = '0;
            end
          end
          OFF_LCR: lcr_nxt = in_wdata;
          OFF_MCR: mcr_nxt = 5'(in_wdata & MCR_MASK);
          OFF_SCR: scr_nxt = in_wdata;
          OFF_LSR, OFF_MSR: ;
          default: ;
        endcase
      end
      CMD_RX: begin
        if (rx_count_r >= RX_FULL) begin
          res_nxt.rx_dropped = 1'b1;
        end else begin
          mem_we            = 1'b1;
          rx_tail_nxt       = next_pos(rx_tail_r);
          rx_count_nxt      = rx_count_r + CNT_W'(1);
          res_nxt.irq_pulse = ier_r[IER_RDI];
        end
      end
      default: ;
    endcase
  end

  // fifo ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && mem_we) begin
      rx_mem_r[rx_tail_r] <= in_wdata;
    end
    if (in_xfer && mem_re) begin
      rd_data_r <= rx_mem_r[rx_head_r];
    end
  end

  // control and register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_count_r  <= '0;
      ier_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      fcr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        rx_head_r  <= rx_head_nxt;
        rx_tail_r  <= rx_tail_nxt;
        rx_count_r <= rx_count_nxt;
        ier_r      <= ier_nxt;
        lcr_r      <= lcr_nxt;
        mcr_r      <= mcr_nxt;
        scr_r      <= scr_nxt;
        fcr_r      <= fcr_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  // outputs; a pop takes its byte from the ram read register
  assign out_valid      = out_valid_r;
  assign out_rdata      = res_r.pop ? rd_data_r : res_r.rdata;
  assign out_irq_pulse  = res_r.irq_pulse;
  assign out_tx_valid   = res_r.tx_valid;
  assign out_tx_data    = res_r.tx_data;
  assign out_rx_dropped = res_r.rx_dropped;

  // fifo occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= RX_FULL)
    else $error("rx fifo count above depth");

  // empty or full fifo has its pointers together
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_count_r == '0 || rx_count_r == RX_FULL) |-> rx_head_r == rx_tail_r)
    else $error("rx fifo pointers disagree with count");

  // a dropped byte never raises an interrupt
  a_drop_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rx_dropped) |-> !out_irq_pulse)
    else $error("interrupt pulse on dropped byte");

  // a pop leaves one byte fewer in the fifo
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && mem_re) |=> rx_count_r == $past(rx_count_r) - CNT_W'(1))
    else $error("rx fifo count not decremented on pop");

endmodule
